### rtl/fpa_pkg.sv
`timescale 1ns / 1ps

package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_DIV  = 4'd3;
	localparam logic [3:0] OP_LT   = 4'd4;
	localparam logic [3:0] OP_GT   = 4'd5;
	localparam logic [3:0] OP_LE   = 4'd6;
	localparam logic [3:0] OP_GE   = 4'd7;
	localparam logic [3:0] OP_EQ   = 4'd8;
	localparam logic [3:0] OP_NE   = 4'd9;
	localparam logic [3:0] OP_MIN  = 4'd10;
	localparam logic [3:0] OP_MAX  = 4'd11;
	localparam logic [3:0] OP_INC  = 4'd12;
	localparam logic [3:0] OP_DEC  = 4'd13;
	localparam logic [3:0] OP_FROM = 4'd14;
	localparam logic [3:0] OP_TO   = 4'd15;

	// Data that rides alongside the divider stages.
	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] res;
		logic        cmp;
		logic        dz;
		logic        neg;
	} side_t;

endpackage

### rtl/fpa_div.sv
`timescale 1ns / 1ps

module fpa_div #(
	parameter int W = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [W-1:0]      dividend,
	input  logic [31:0]       divisor,
	input  fpa_pkg::side_t    side_in,
	output logic              out_valid,
	output logic [W-1:0]      quotient,
	output fpa_pkg::side_t    side_out
);
	import fpa_pkg::*;

	logic [31:0]  rem_s  [0:W];
	logic [W-1:0] dvd_s  [0:W];
	logic [31:0]  dvs_s  [0:W];
	side_t        side_s [0:W];
	logic [W:0]   vld_s;

	assign rem_s[0]  = '0;
	assign dvd_s[0]  = dividend;
	assign dvs_s[0]  = divisor;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	// One quotient bit per stage; the dividend register fills with quotient bits.
	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [32:0] t;
		logic [32:0] diff;
		logic        ge;
		assign t    = {rem_s[i], dvd_s[i][W-1]};
		assign diff = t - {1'b0, dvs_s[i]};
		assign ge   = t >= {1'b0, dvs_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[31:0] : t[31:0];
				dvd_s[i+1]  <= {dvd_s[i][W-2:0], ge};
				dvs_s[i+1]  <= dvs_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[W];
	assign quotient  = dvd_s[W];
	assign side_out  = side_s[W];

endmodule

### rtl/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
// An input register, the divider stages and an output register lie between input transfer and result.
// Throughput: one item per cycle while the output is not stalled; every operation flows through the same pipeline.
// The pipeline length is set by the divider, which resolves one quotient bit per stage.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Reset (arst_n low, asynchronous) clears all valid bits; data registers are not reset.

module fixed_point_q24_8_alu #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         operation,
	input  logic signed [31:0] a_raw,
	input  logic signed [31:0] b_raw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_raw,
	output logic               compare_true,
	output logic               divide_by_zero
);
	import fpa_pkg::*;

	localparam int W = 32 + FRAC_BITS;

	logic               adv;
	logic               in_xfer;
	logic [31:0]        a_mag;
	logic [31:0]        b_mag;
	logic signed [31:0] res_c;
	logic               cmp_c;

	logic               valid_s1;
	logic [3:0]         op_s1;
	logic [31:0]        res_s1;
	logic               cmp_s1;
	logic               dz_s1;
	logic               neg_s1;
	logic signed [63:0] prod_s1;
	logic [W-1:0]       dvd_s1;
	logic [31:0]        dvs_s1;

	side_t              side_in;
	side_t              side_out;
	logic               div_valid;
	logic [W-1:0]       quot;
	logic [31:0]        q_signed;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign in_xfer  = in_valid && adv;

	assign a_mag = a_raw[31] ? 32'(-a_raw) : a_raw;
	assign b_mag = b_raw[31] ? 32'(-b_raw) : b_raw;

	always_comb begin
		res_c = '0;
		cmp_c = 1'b0;
		case (operation)
			OP_ADD:  res_c = a_raw + b_raw;
			OP_SUB:  res_c = a_raw - b_raw;
			OP_LT:   cmp_c = a_raw < b_raw;
			OP_GT:   cmp_c = a_raw > b_raw;
			OP_LE:   cmp_c = a_raw <= b_raw;
			OP_GE:   cmp_c = a_raw >= b_raw;
			OP_EQ:   cmp_c = a_raw == b_raw;
			OP_NE:   cmp_c = a_raw != b_raw;
			OP_MIN:  res_c = (a_raw < b_raw) ? a_raw : b_raw;
			OP_MAX:  res_c = (a_raw > b_raw) ? a_raw : b_raw;
			OP_INC:  res_c = a_raw + 32'sd1;
			OP_DEC:  res_c = a_raw - 32'sd1;
			OP_FROM: res_c = a_raw <<< FRAC_BITS;
			OP_TO:   res_c = a_raw >>> FRAC_BITS;
			default: res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= operation;
			res_s1  <= res_c;
			cmp_s1  <= cmp_c;
			dz_s1   <= (operation == OP_DIV) && (b_raw == 32'sd0);
			neg_s1  <= a_raw[31] ^ b_raw[31];
			prod_s1 <= 64'(a_raw) * 64'(b_raw);
			dvd_s1  <= W'(a_mag) << FRAC_BITS;
			dvs_s1  <= b_mag;
		end
	end

	// The floor shift of the product followed by wrapping is just a bit slice.
	always_comb begin
		side_in.op  = op_s1;
		side_in.res = (op_s1 == OP_MUL) ? prod_s1[FRAC_BITS +: 32] : res_s1;
		side_in.cmp = cmp_s1;
		side_in.dz  = dz_s1;
		side_in.neg = neg_s1;
	end

	fpa_div #(
		.W(W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s1),
		.dividend  (dvd_s1),
		.divisor   (dvs_s1),
		.side_in   (side_in),
		.out_valid (div_valid),
		.quotient  (quot),
		.side_out  (side_out)
	);

	assign q_signed = side_out.neg ? 32'(-quot[31:0]) : quot[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_out.op == OP_DIV) begin
				result_raw <= side_out.dz ? 32'sd0 : q_signed;
			end else begin
				result_raw <= side_out.res;
			end
			compare_true   <= side_out.cmp;
			divide_by_zero <= side_out.dz;
		end
	end

endmodule

### rtl/fpa_check.sv
`timescale 1ns / 1ps

module fpa_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [3:0]         operation,
	input logic signed [31:0] a_raw,
	input logic signed [31:0] b_raw,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] result_raw,
	input logic               compare_true,
	input logic               divide_by_zero
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(a_raw)
			&& $stable(b_raw))
		else $error("input transfer changed while waiting");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_raw))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_raw == 32'sd0 && !compare_true)
		else $error("divide by zero result not cleared");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> result_raw == 32'sd0 && !divide_by_zero)
		else $error("comparison carries a nonzero result");

endmodule

bind fixed_point_q24_8_alu fpa_check u_fpa_check (.*);
